// ===== design/ssp_pkg.sv =====
`default_nettype none
package ssp_pkg;

	localparam int ANGLE_FRAC_BITS = 16;
	localparam int CORDIC_STEPS = 18;
	localparam int OUT_SHIFT = 32 - ANGLE_FRAC_BITS;
	localparam int OUT_RND = 1 << (OUT_SHIFT - 1);

	localparam int CW = 34;
	localparam int ISQ_STEPS = 31;
	localparam int ISQ_LAT = ISQ_STEPS + 1;
	localparam int SIN_LAT = CORDIC_STEPS + 1;
	localparam int PIPE_DEPTH = 45 + 3 * SIN_LAT;
	localparam int LON_DLY = 35 + 2 * SIN_LAT;

	typedef logic signed [CW-1:0] cdata_t;

	localparam logic [127:0] RATE_L_W = (128'd9856474 << 38) / 128'd3515625;
	localparam logic [127:0] RATE_M_W = (128'd9856003 << 38) / 128'd3515625;
	localparam logic [127:0] BASE_L_W = ((128'd14023 << 40) / 128'd18000) << 24;
	localparam logic [127:0] BASE_M_W = ((128'd44691 << 40) / 128'd45000) << 24;
	localparam logic [127:0] COEF_C1_W = (128'd1915 << 32) / 128'd360000;
	localparam logic [127:0] COEF_C2_W = (128'd20 << 32) / 128'd360000;
	localparam logic [127:0] EPS0_W = (128'd23439 << 32) / 128'd360000;
	localparam logic [127:0] RECIP_W = (128'd1 << 48) / 128'd3515625;

	localparam logic [63:0] RATE_L = RATE_L_W[63:0];
	localparam logic [63:0] RATE_M = RATE_M_W[63:0];
	localparam logic [63:0] BASE_L = BASE_L_W[63:0];
	localparam logic [63:0] BASE_M = BASE_M_W[63:0];
	localparam logic [25:0] COEF_C1 = COEF_C1_W[25:0];
	localparam logic [25:0] COEF_C2 = COEF_C2_W[25:0];
	localparam logic [31:0] EPS0 = EPS0_W[31:0];
	localparam logic [26:0] RECIP = RECIP_W[26:0];
	localparam logic [21:0] EPS_DIV = 22'd3515625;

	localparam cdata_t GAIN_C = CW'(64'sd652032874);
	localparam cdata_t QTURN = CW'(64'sd1073741824);
	localparam cdata_t HTURN = CW'(64'sd2147483648);

	localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;
	localparam logic signed [45:0] ST_WRAP = 46'sd1440 << 32;
	localparam logic signed [45:0] LON_180 = 46'sd180 << 32;
	localparam logic signed [45:0] LON_360 = 46'sd360 << 32;

	localparam logic [31:0] ATAN_TURN [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};

	function automatic cdata_t atan_c(input int i);
		return cdata_t'({{(CW-32){1'b0}}, ATAN_TURN[i]});
	endfunction

endpackage
`default_nettype wire

// ===== design/ssp_front.sv =====
`default_nettype none
module ssp_front import ssp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               adv,
	input  wire logic signed [32:0] day_offset,
	input  wire logic [4:0]         utc_hour,
	input  wire logic [5:0]         utc_minute,
	output logic [31:0]             l32,
	output logic [31:0]             m32,
	output logic [31:0]             eps,
	output logic [10:0]             mins
);

	logic [63:0] d64;
	logic [32:0] absd;
	logic [63:0] lsum, msum;
	logic [41:0] r4;
	logic [19:0] q4;

	logic [63:0] ll_s1, ml_s1;
	logic [31:0] lh_s1, mh_s1;
	logic [59:0] ep_s1;
	logic [32:0] absd_s1, absd_s2, absd_s3;
	logic        neg_s1, neg_s2, neg_s3;
	logic [10:0] mins_s1, mins_s2, mins_s3, mins_s4;
	logic [31:0] l32_s2, l32_s3, l32_s4, m32_s2, m32_s3, m32_s4, eps_s4;
	logic [19:0] q0_s2, q0_s3;
	logic [41:0] qc_s3;

	always_comb begin
		d64 = {{31{day_offset[32]}}, day_offset};
		absd = day_offset[32] ? 33'(-day_offset) : day_offset;
		lsum = BASE_L + ll_s1 + {lh_s1, 32'b0};
		msum = BASE_M + ml_s1 + {mh_s1, 32'b0};
		r4 = {1'b0, absd_s3, 8'b0} - qc_s3;
		q4 = q0_s3 + 20'(r4 >= 42'(EPS_DIV));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// phase partial products and reciprocal estimate
			ll_s1 <= d64 * {32'b0, RATE_L[31:0]};
			lh_s1 <= day_offset[31:0] * RATE_L[63:32];
			ml_s1 <= d64 * {32'b0, RATE_M[31:0]};
			mh_s1 <= day_offset[31:0] * RATE_M[63:32];
			ep_s1 <= 60'(absd) * 60'(RECIP);
			absd_s1 <= absd;
			neg_s1 <= day_offset[32];
			mins_s1 <= 11'(utc_hour) * 11'd60 + 11'(utc_minute);

			l32_s2 <= lsum[63:32];
			m32_s2 <= msum[63:32];
			q0_s2 <= ep_s1[59:40];
			absd_s2 <= absd_s1;
			neg_s2 <= neg_s1;
			mins_s2 <= mins_s1;

			qc_s3 <= 42'(q0_s2) * 42'(EPS_DIV);
			q0_s3 <= q0_s2;
			absd_s3 <= absd_s2;
			neg_s3 <= neg_s2;
			l32_s3 <= l32_s2;
			m32_s3 <= m32_s2;
			mins_s3 <= mins_s2;

			// quotient correction, obliquity
			eps_s4 <= neg_s3 ? EPS0 + 32'(q4) : EPS0 - 32'(q4);
			l32_s4 <= l32_s3;
			m32_s4 <= m32_s3;
			mins_s4 <= mins_s3;
		end
	end

	assign l32 = l32_s4;
	assign m32 = m32_s4;
	assign eps = eps_s4;
	assign mins = mins_s4;

endmodule
`default_nettype wire

// ===== design/ssp_sin.sv =====
`default_nettype none
module ssp_sin import ssp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        adv,
	input  wire logic [31:0] angle,
	output cdata_t           sine
);

	cdata_t a_ext, fold;
	cdata_t x_s [CORDIC_STEPS+1];
	cdata_t y_s [CORDIC_STEPS+1];
	cdata_t z_s [CORDIC_STEPS+1];

	// fold into a quarter turn either side of zero
	always_comb begin
		a_ext = {{(CW-32){angle[31]}}, angle};
		if (a_ext > QTURN) begin
			fold = HTURN - a_ext;
		end else if (a_ext < -QTURN) begin
			fold = -HTURN - a_ext;
		end else begin
			fold = a_ext;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0] <= GAIN_C;
			y_s[0] <= '0;
			z_s[0] <= fold;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				if (!z_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_c(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_c(i);
				end
			end
		end
	end

	assign sine = y_s[CORDIC_STEPS];

endmodule
`default_nettype wire

// ===== design/ssp_isqrt.sv =====
`default_nettype none
module ssp_isqrt import ssp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        adv,
	input  wire logic [60:0] radicand,
	output logic [30:0]      root
);

	logic [61:0] v_s [ISQ_STEPS+1];
	logic [61:0] r_s [ISQ_STEPS+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s[0] <= {1'b0, radicand};
			r_s[0] <= '0;
			for (int i = 0; i < ISQ_STEPS; i++) begin
				if (v_s[i] >= r_s[i] + (62'(1) << (2 * (ISQ_STEPS - 1 - i)))) begin
					v_s[i+1] <= v_s[i] - (r_s[i] + (62'(1) << (2 * (ISQ_STEPS - 1 - i))));
					r_s[i+1] <= (r_s[i] >> 1) + (62'(1) << (2 * (ISQ_STEPS - 1 - i)));
				end else begin
					v_s[i+1] <= v_s[i];
					r_s[i+1] <= r_s[i] >> 1;
				end
			end
		end
	end

	assign root = r_s[ISQ_STEPS][30:0];

endmodule
`default_nettype wire

// ===== design/ssp_atan.sv =====
`default_nettype none
module ssp_atan import ssp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               adv,
	input  wire logic signed [31:0] y_in,
	input  wire logic [30:0]        x_in,
	output cdata_t                  angle
);

	cdata_t x_s [CORDIC_STEPS+1];
	cdata_t y_s [CORDIC_STEPS+1];
	cdata_t z_s [CORDIC_STEPS+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0] <= cdata_t'({{(CW-31){1'b0}}, x_in});
			y_s[0] <= CW'(y_in);
			z_s[0] <= '0;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				if (!y_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_c(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_c(i);
				end
			end
		end
	end

	assign angle = z_s[CORDIC_STEPS];

endmodule
`default_nettype wire

// ===== design/subsolar_point.sv =====
`default_nettype none
// subsolar point from a timestamp
// input transaction: s_tdata holds the day count since j2000 in 1/65536 day, the utc
// hour and the utc minute; output transaction: m_tdata holds subsolar latitude and
// longitude in degrees times 2^16, longitude wrapped into -180..180
// fully pipelined, no state between transactions: one transaction per cycle while s_tready is high
// the path from input to output runs through three cordic chains (sin of mean
// anomaly and obliquity, sin of ecliptic longitude, atan of the declination) and
// the 31-step square root
// reset clears the pipeline valid bits and the output and skid valid flags only
// when m_tready is low the output register holds its result and one more result
// lands in a skid register; the pipeline then freezes and s_tready drops until
// the skid register drains, so nothing is lost or repeated
module subsolar_point import ssp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // day_offset[32:0], utc_hour[37:33], utc_minute[43:38]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata   // latitude[23:0], longitude[48:24]
);

	logic adv;
	logic [PIPE_DEPTH-1:0] vld_s;

	logic [31:0] l32_f, m32_f, eps_f;
	logic [10:0] mins_f;
	cdata_t sm, s2m, seps, slam, dec;
	logic [30:0] root;

	logic [42:0] sb_q [SIN_LAT];
	cdata_t seps_q [SIN_LAT];
	logic signed [31:0] sdec_q [ISQ_LAT];
	logic [24:0] lon_q_d [LON_DLY];

	logic signed [59:0] pc1_s1, pc2_s1;
	logic [31:0] l32_s1, l32_s2;
	logic [10:0] mins_s1, mins_s2, mins_s3;
	cdata_t seps_s1, seps_s2, seps_s3;
	logic signed [31:0] eoc_s2;
	logic [31:0] lam_s3;
	logic signed [41:0] e360_s3;
	logic signed [45:0] st_raw, st_s4, lon_raw, lon_s5, lon_rnd;
	logic [24:0] lon_s6;
	logic signed [63:0] pr_s7, sh;
	logic signed [31:0] sdec_s8, sdec_s9, sdec_s10;
	logic [60:0] sq_s9, v_s10;
	logic signed [43:0] dm_s11, lat_rnd;
	logic [23:0] lat_s12;

	logic        out_vld_q, skid_vld_q;
	logic [23:0] lat_q, skid_lat_q;
	logic [24:0] lon_q, skid_lon_q;

	assign adv = !skid_vld_q;
	assign s_tready = adv;

	ssp_front u_front (
		.clk        (clk),
		.adv        (adv),
		.day_offset (s_tdata[32:0]),
		.utc_hour   (s_tdata[37:33]),
		.utc_minute (s_tdata[43:38]),
		.l32        (l32_f),
		.m32        (m32_f),
		.eps        (eps_f),
		.mins       (mins_f)
	);

	ssp_sin u_sin_m (.clk(clk), .adv(adv), .angle(m32_f), .sine(sm));
	ssp_sin u_sin_2m (.clk(clk), .adv(adv), .angle({m32_f[30:0], 1'b0}), .sine(s2m));
	ssp_sin u_sin_eps (.clk(clk), .adv(adv), .angle(eps_f), .sine(seps));
	ssp_sin u_sin_lam (.clk(clk), .adv(adv), .angle(lam_s3), .sine(slam));

	ssp_isqrt u_isqrt (.clk(clk), .adv(adv), .radicand(v_s10), .root(root));

	ssp_atan u_atan (
		.clk   (clk),
		.adv   (adv),
		.y_in  (sdec_q[ISQ_LAT-1]),
		.x_in  (root),
		.angle (dec)
	);

	always_comb begin
		st_raw = $signed({3'b0, mins_s3, 32'b0}) - 46'(e360_s3);
		lon_raw = LON_180 - (st_s4 >>> 2);
		lon_rnd = (lon_s5 + 46'(OUT_RND)) >>> OUT_SHIFT;
		sh = pr_s7 >>> 30;
		lat_rnd = (dm_s11 + 44'(OUT_RND)) >>> OUT_SHIFT;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_q[0] <= {l32_f, mins_f};
			seps_q[0] <= seps_s3;
			sdec_q[0] <= sdec_s10;
			lon_q_d[0] <= lon_s6;
			for (int i = 1; i < SIN_LAT; i++) begin
				sb_q[i] <= sb_q[i-1];
				seps_q[i] <= seps_q[i-1];
			end
			for (int i = 1; i < ISQ_LAT; i++) begin
				sdec_q[i] <= sdec_q[i-1];
			end
			for (int i = 1; i < LON_DLY; i++) begin
				lon_q_d[i] <= lon_q_d[i-1];
			end

			// equation of center
			pc1_s1 <= sm * $signed({1'b0, COEF_C1});
			pc2_s1 <= s2m * $signed({1'b0, COEF_C2});
			l32_s1 <= sb_q[SIN_LAT-1][42:11];
			mins_s1 <= sb_q[SIN_LAT-1][10:0];
			seps_s1 <= seps;

			eoc_s2 <= 32'((pc1_s1 >>> 30) + (pc2_s1 >>> 30));
			l32_s2 <= l32_s1;
			mins_s2 <= mins_s1;
			seps_s2 <= seps_s1;

			lam_s3 <= l32_s2 + eoc_s2;
			e360_s3 <= 42'(eoc_s2) * 42'sd360;
			mins_s3 <= mins_s2;
			seps_s3 <= seps_s2;

			// solar time and longitude
			st_s4 <= (st_raw >= ST_WRAP) ? st_raw - ST_WRAP : st_raw;
			lon_s5 <= (lon_raw > LON_180) ? lon_raw - LON_360 : lon_raw;
			lon_s6 <= lon_rnd[24:0];

			// declination
			pr_s7 <= 64'(seps_q[SIN_LAT-1]) * 64'(slam);
			if (sh > ONE_Q30) begin
				sdec_s8 <= 32'(ONE_Q30);
			end else if (sh < -ONE_Q30) begin
				sdec_s8 <= 32'(-ONE_Q30);
			end else begin
				sdec_s8 <= 32'(sh);
			end
			sq_s9 <= 61'(64'(sdec_s8) * 64'(sdec_s8));
			sdec_s9 <= sdec_s8;
			v_s10 <= (61'(1) << 60) - sq_s9;
			sdec_s10 <= sdec_s9;

			dm_s11 <= 44'(dec) * 44'sd360;
			lat_s12 <= lat_rnd[23:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[PIPE_DEPTH-2:0], s_tvalid};
		end
	end

	// output register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (m_tready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (!out_vld_q || m_tready) begin
			out_vld_q <= vld_s[PIPE_DEPTH-1];
		end else if (vld_s[PIPE_DEPTH-1]) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (m_tready) begin
				lat_q <= skid_lat_q;
				lon_q <= skid_lon_q;
			end
		end else if (!out_vld_q || m_tready) begin
			lat_q <= lat_s12;
			lon_q <= lon_q_d[LON_DLY-1];
		end else begin
			skid_lat_q <= lat_s12;
			skid_lon_q <= lon_q_d[LON_DLY-1];
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = {7'b0, lon_q, lat_q};

endmodule
`default_nettype wire

// ===== sim/tb_subsolar_point.sv =====
module tb_subsolar_point;
	import ssp_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 2 * PIPE_DEPTH;
	localparam longint DAY_SPAN = 64'sd2393702400;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;  // day_offset[32:0], utc_hour[37:33], utc_minute[43:38]
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;  // latitude[23:0], longitude[48:24]

	typedef struct packed {
		logic [24:0] longitude;
		logic [23:0] latitude;
	} position_t;

	position_t expected_positions[$];
	int errors;
	int sent_count;
	int checked_count;
	int idle_pct;
	int stall_pct;
	int quiet_cycles;

	subsolar_point u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic longint cordic_sin(input logic [31:0] ang);
		longint s;
		longint x;
		longint y;
		longint dx;
		longint dy;
		s = longint'(ang);
		x = 652032874;
		y = 0;
		if (s >= (64'sd1 << 31))
			s -= (64'sd1 << 32);
		if (s > (64'sd1 << 30))
			s = (64'sd1 << 31) - s;
		else if (s < -(64'sd1 << 30))
			s = -(64'sd1 << 31) - s;
		for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (s >= 0) begin
				x -= dx; y += dy; s -= longint'(ATAN_TURN[i]);
			end else begin
				x += dx; y -= dy; s += longint'(ATAN_TURN[i]);
			end
		end
		return y;
	endfunction

	function automatic longint cordic_atan(input longint y, input longint x);
		longint z;
		longint dx;
		longint dy;
		z = 0;
		for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
			end else begin
				x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
			end
		end
		return z;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint deg_to_out(input longint v);
		return (v + (64'sd1 << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
	endfunction

	function automatic position_t subsolar_of(input logic [32:0] day, input logic [4:0] hr,
			input logic [5:0] mn);
		longint d;
		logic [63:0] lph;
		logic [63:0] mph;
		logic [31:0] m32;
		logic [31:0] lam;
		longint eoc;
		longint eps;
		longint sdec;
		longint cdec;
		longint dec;
		longint st;
		longint lon;
		longint lat_o;
		longint lon_o;
		position_t p;
		d = longint'($signed(day));
		lph = BASE_L + 64'(d) * RATE_L;
		mph = BASE_M + 64'(d) * RATE_M;
		m32 = mph[63:32];
		eoc = ((longint'(COEF_C1) * cordic_sin(m32)) >>> 30)
			+ ((longint'(COEF_C2) * cordic_sin({m32[30:0], 1'b0})) >>> 30);
		lam = lph[63:32] + eoc[31:0];
		eps = longint'(EPS0) - (d * 256) / 64'sd3515625;
		sdec = (cordic_sin(eps[31:0]) * cordic_sin(lam)) >>> 30;
		if (sdec > ONE_Q30)
			sdec = ONE_Q30;
		if (sdec < -ONE_Q30)
			sdec = -ONE_Q30;
		cdec = longint'(int_sqrt((64'd1 << 60) - 64'(sdec * sdec)));
		dec = cordic_atan(sdec, cdec);
		st = ((longint'(hr) * 60 + longint'(mn)) <<< 32) - 360 * eoc;
		if (st >= (64'sd1440 <<< 32))
			st -= (64'sd1440 <<< 32);
		lon = (64'sd180 <<< 32) - (st >>> 2);
		if (lon > (64'sd180 <<< 32))
			lon -= (64'sd360 <<< 32);
		lat_o = deg_to_out(dec * 360);
		lon_o = deg_to_out(lon);
		p.latitude = lat_o[23:0];
		p.longitude = lon_o[24:0];
		return p;
	endfunction

	task automatic send_timestamp(input logic [32:0] day, input logic [4:0] hr,
			input logic [5:0] mn);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, mn, hr, day};
		do
			@(posedge clk);
		while (!s_tready);
		expected_positions.push_back(subsolar_of(day, hr, mn));
		sent_count++;
		@(negedge clk);
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		position_t got;
		position_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[48:0];
			if (expected_positions.size() == 0) begin
				$display("%0t unexpected transaction: actual lat %h lon %h", $time,
					got.latitude, got.longitude);
				errors++;
			end else begin
				want = expected_positions.pop_front();
				if (got.latitude !== want.latitude) begin
					$display("%0t latitude mismatch: expected %h actual %h", $time,
						want.latitude, got.latitude);
					errors++;
				end
				if (got.longitude !== want.longitude) begin
					$display("%0t longitude mismatch: expected %h actual %h", $time,
						want.longitude, got.longitude);
					errors++;
				end
			end
			checked_count++;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d idle cycles", quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [32:0] random_day();
		int pick;
		longint v;
		pick = $urandom_range(9);
		if (pick < 7)
			v = longint'($urandom_range(32'hFFFF_FFFF)) % (2 * DAY_SPAN + 1) - DAY_SPAN;
		else if (pick < 9)
			return {$urandom(), 1'($urandom())};
		else
			v = (pick[0] ? DAY_SPAN : -DAY_SPAN) + $signed($urandom_range(8)) - 4;
		return v[32:0];
	endfunction

	task automatic test_directed();
		logic [32:0] days[8];
		days = '{33'd0, 33'd1, -33'sd1, 33'(DAY_SPAN), 33'(-DAY_SPAN),
			33'h0_FFFF_FFFF, 33'h1_0000_0000, 33'h0_0100_0000};
		idle_pct = 0;
		stall_pct = 0;
		foreach (days[i])
			send_timestamp(days[i], 5'(i * 3), 6'(i * 8));
		send_timestamp(33'd0, 5'd0, 6'd0);
		send_timestamp(33'd0, 5'd23, 6'd59);
		send_timestamp(33'd0, 5'd31, 6'd63);
		send_timestamp(33'h1_0000_0000, 5'd31, 6'd63);
		send_timestamp(33'd1234567, 5'd24, 6'd0);
		send_timestamp(33'd9999999, 5'd12, 6'd60);
		send_timestamp(-33'sd5000000, 5'd0, 6'd1);
		send_timestamp(33'd20000000, 5'd23, 6'd58);
	endtask

	task automatic test_random(input int count, input int idle, input int stall);
		logic [4:0] hr;
		logic [5:0] mn;
		idle_pct = idle;
		stall_pct = stall;
		repeat (count) begin
			hr = ($urandom_range(9) == 0) ? 5'($urandom()) : 5'($urandom_range(23));
			mn = ($urandom_range(9) == 0) ? 6'($urandom()) : 6'($urandom_range(59));
			send_timestamp(random_day(), hr, mn);
		end
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (expected_positions.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		errors = 0;
		sent_count = 0;
		checked_count = 0;
		quiet_cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(490, 0, 0);
		test_random(490, 69, 0);
		test_random(490, 0, 69);
		test_random(490, 8, 8);
		wait_drain();
		$display("sent %0d timestamps, checked %0d positions over four handshake phases",
			sent_count, checked_count);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
